@@ design/mams_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mams_pkg;

    // Field and register widths
    localparam int unsigned DIFF_W     = 24;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned MODE_W     = 7;
    localparam int unsigned MOTION_W   = 13;
    localparam int unsigned MISMATCH_W = 14;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned CFG_IDX_W  = 3;

    // Quiet counter saturates here
    localparam logic [COUNT_W-1:0] QUIET_MAX = '1;

    // Register reset values
    localparam logic [COUNT_W-1:0]    RST_LOW_MOTION_COUNT   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0]    RST_STATIC_COUNT       = COUNT_W'(100);
    localparam logic [MODE_W-1:0]     RST_STATIC_MODE        = MODE_W'(0);
    localparam logic [MODE_W-1:0]     RST_LOW_MODE           = MODE_W'(1);
    localparam logic [MODE_W-1:0]     RST_HIGH_MODE          = MODE_W'(1);
    localparam logic [MOTION_W-1:0]   RST_MOTION_THRESHOLD   = MOTION_W'(15);
    localparam logic [MISMATCH_W-1:0] RST_MISMATCH_THRESHOLD = MISMATCH_W'(900);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_MOTION_COUNT   = 3'd0,
        REG_STATIC_COUNT       = 3'd1,
        REG_STATIC_MODE        = 3'd2,
        REG_LOW_MODE           = 3'd3,
        REG_HIGH_MODE          = 3'd4,
        REG_MOTION_THRESHOLD   = 3'd5,
        REG_MISMATCH_THRESHOLD = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ design/motion_adaptive_mode_selector.sv @@
// Motion-adaptive mode selector.
// Input channel: one request per video field (field_difference, fields_present),
// accepted when in_valid is high and in_stall is low. Output channel: one
// request per input (selected_mode, processed), taken when out_valid is high
// and out_stall is low. Configuration: cfg_we/cfg_index/cfg_data write one
// register per cycle; write only while no request is in flight.
// Path: an accepted request passes through an input register, then the decision
// logic into the result register.
// Throughput: one request per cycle unless stalled; the mode and quiet count
// update in the result stage, so back-to-back fields see each other's state.
// Reset: asynchronous, active low; configuration registers return to their
// default values, no mode is chosen yet and the quiet count is zero. The first
// field after reset starts from the high motion mode.
// Stall: when out_stall holds a waiting result, the input register still takes
// one more request; in_stall rises only once that register is also full.
`timescale 1ns / 1ps
`default_nettype none

module motion_adaptive_mode_selector (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [mams_pkg::DIFF_W-1:0]         field_difference,
    input  wire logic                                fields_present,
    // output channel
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic [mams_pkg::MODE_W-1:0]         selected_mode,
    output      logic                                processed,
    // configuration port
    input  wire logic                                cfg_we,
    input  wire logic [mams_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mams_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [mams_pkg::COUNT_W-1:0]    low_motion_count_reg;
    logic [mams_pkg::COUNT_W-1:0]    static_count_reg;
    logic [mams_pkg::MODE_W-1:0]     static_mode_reg;
    logic [mams_pkg::MODE_W-1:0]     low_mode_reg;
    logic [mams_pkg::MODE_W-1:0]     high_mode_reg;
    logic [mams_pkg::MOTION_W-1:0]   motion_threshold_reg;
    logic [mams_pkg::MISMATCH_W-1:0] mismatch_threshold_reg;

    // Pipeline and state
    logic                            s1_valid_reg;
    logic [mams_pkg::DIFF_W-1:0]     s1_diff_reg;
    logic                            s1_present_reg;
    logic                            out_valid_reg;
    logic [mams_pkg::MODE_W-1:0]     out_mode_reg;
    logic                            out_processed_reg;
    logic [mams_pkg::MODE_W-1:0]     current_mode_reg;
    logic [mams_pkg::MODE_W-1:0]     current_mode_next;
    logic                            mode_chosen_reg;
    logic [mams_pkg::COUNT_W-1:0]    quiet_count_reg;
    logic [mams_pkg::COUNT_W-1:0]    quiet_count_next;

    logic s2_ready;
    logic s2_load;
    logic s1_load;

    // Handshake
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign s1_load  = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_motion_count_reg   <= mams_pkg::RST_LOW_MOTION_COUNT;
            static_count_reg       <= mams_pkg::RST_STATIC_COUNT;
            static_mode_reg        <= mams_pkg::RST_STATIC_MODE;
            low_mode_reg           <= mams_pkg::RST_LOW_MODE;
            high_mode_reg          <= mams_pkg::RST_HIGH_MODE;
            motion_threshold_reg   <= mams_pkg::RST_MOTION_THRESHOLD;
            mismatch_threshold_reg <= mams_pkg::RST_MISMATCH_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (mams_pkg::cfg_reg_t'(cfg_index))
                mams_pkg::REG_LOW_MOTION_COUNT:
                    low_motion_count_reg <= cfg_data[mams_pkg::COUNT_W-1:0];
                mams_pkg::REG_STATIC_COUNT:
                    static_count_reg <= cfg_data[mams_pkg::COUNT_W-1:0];
                mams_pkg::REG_STATIC_MODE:
                    static_mode_reg <= cfg_data[mams_pkg::MODE_W-1:0];
                mams_pkg::REG_LOW_MODE:
                    low_mode_reg <= cfg_data[mams_pkg::MODE_W-1:0];
                mams_pkg::REG_HIGH_MODE:
                    high_mode_reg <= cfg_data[mams_pkg::MODE_W-1:0];
                mams_pkg::REG_MOTION_THRESHOLD:
                    motion_threshold_reg <= cfg_data[mams_pkg::MOTION_W-1:0];
                mams_pkg::REG_MISMATCH_THRESHOLD:
                    mismatch_threshold_reg <= cfg_data[mams_pkg::MISMATCH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_diff_reg    <= field_difference;
            s1_present_reg <= fields_present;
        end
    end

    // Mode decision
    always_comb
    begin
        logic [mams_pkg::MODE_W-1:0]  base_mode;
        logic [mams_pkg::MODE_W-1:0]  quiet_mode;
        logic [mams_pkg::COUNT_W-1:0] quiet_inc;
        logic                         moving;
        logic                         small_mismatch;

        base_mode = mode_chosen_reg ? current_mode_reg : high_mode_reg;
        moving = s1_diff_reg >
                 {{(mams_pkg::DIFF_W-mams_pkg::MOTION_W){1'b0}}, motion_threshold_reg};
        small_mismatch = s1_diff_reg <
                 {{(mams_pkg::DIFF_W-mams_pkg::MISMATCH_W){1'b0}}, mismatch_threshold_reg};
        quiet_inc = (quiet_count_reg != mams_pkg::QUIET_MAX)
                    ? quiet_count_reg + mams_pkg::COUNT_W'(1) : quiet_count_reg;

        // quiet field: high -> low, then low -> static on the updated mode
        quiet_mode = base_mode;
        if (quiet_inc >= low_motion_count_reg && quiet_mode == high_mode_reg)
        begin
            quiet_mode = low_mode_reg;
        end
        if (quiet_inc >= static_count_reg && quiet_mode == low_mode_reg)
        begin
            quiet_mode = static_mode_reg;
        end

        current_mode_next = base_mode;
        quiet_count_next  = quiet_count_reg;
        if (s1_present_reg)
        begin
            if (moving)
            begin
                quiet_count_next = '0;
                if (base_mode == static_mode_reg && small_mismatch)
                begin
                    current_mode_next = low_mode_reg;
                end
                else
                begin
                    current_mode_next = high_mode_reg;
                end
            end
            else
            begin
                quiet_count_next  = quiet_inc;
                current_mode_next = quiet_mode;
            end
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_mode_reg <= '0;
            mode_chosen_reg  <= 1'b0;
            quiet_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s2_load)
            begin
                current_mode_reg <= current_mode_next;
                mode_chosen_reg  <= 1'b1;
                quiet_count_reg  <= quiet_count_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_mode_reg      <= current_mode_next;
            out_processed_reg <= s1_present_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign selected_mode = out_mode_reg;
    assign processed     = out_processed_reg;

`ifndef NO_ASSERTIONS
    // any evaluated field leaves a chosen mode behind
    a_mode_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> mode_chosen_reg)
        else $error("mode not marked chosen after a field");

    // input side stalls only when the input register holds a request
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a waiting request");

    // a field with missing halves keeps mode and count once a mode is chosen
    a_missing_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && !s1_present_reg && mode_chosen_reg) |=>
            ($stable(current_mode_reg) && $stable(quiet_count_reg)))
        else $error("state changed on a field with missing halves");

    // the result register reports the mode the state holds
    a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (out_mode_reg == current_mode_reg))
        else $error("reported mode differs from stored mode");
`endif

endmodule

`default_nettype wire

@@ sim/tb_motion_adaptive_mode_selector.sv @@
`timescale 1ns / 1ps

module tb_motion_adaptive_mode_selector;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_GAP       = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 50;
    localparam int RANDOM_PHASES = 9;
    localparam int HOLD_PHASE    = 3;
    localparam int QUIET_ITEMS   = 60;
    localparam int CFG_ROW       = 2;    // directed rows before this one run on reset values
    localparam int REPORT_LIMIT  = 10;
    localparam longint LIMIT_NS  = 5_000_000;

    // index outside the register map; writes to it must be ignored
    localparam logic [mams_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [mams_pkg::MODE_W-1:0] mode;
        logic                        processed;
    } mode_result_t;

    typedef struct {
        logic [mams_pkg::DIFF_W-1:0] diff;
        logic                        present;
        bit                          typed;
        mode_result_t                result;
    } field_row_t;

    // DUT signals
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [mams_pkg::DIFF_W-1:0]     field_difference;
    logic                            fields_present;
    logic                            out_valid;
    logic                            out_stall;
    logic [mams_pkg::MODE_W-1:0]     selected_mode;
    logic                            processed;
    logic                            cfg_we;
    logic [mams_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mams_pkg::CFG_DATA_W-1:0] cfg_data;

    // register shadow
    logic [mams_pkg::COUNT_W-1:0]    cfg_low_count    = mams_pkg::RST_LOW_MOTION_COUNT;
    logic [mams_pkg::COUNT_W-1:0]    cfg_static_count = mams_pkg::RST_STATIC_COUNT;
    logic [mams_pkg::MODE_W-1:0]     cfg_static_mode  = mams_pkg::RST_STATIC_MODE;
    logic [mams_pkg::MODE_W-1:0]     cfg_low_mode     = mams_pkg::RST_LOW_MODE;
    logic [mams_pkg::MODE_W-1:0]     cfg_high_mode    = mams_pkg::RST_HIGH_MODE;
    logic [mams_pkg::MOTION_W-1:0]   cfg_motion_thr   = mams_pkg::RST_MOTION_THRESHOLD;
    logic [mams_pkg::MISMATCH_W-1:0] cfg_mismatch_thr = mams_pkg::RST_MISMATCH_THRESHOLD;

    // mode selection state
    logic [mams_pkg::MODE_W-1:0]     pred_mode  = '0;
    logic                            mode_set   = 1'b0;
    logic [mams_pkg::COUNT_W-1:0]    quiet_run  = '0;

    mode_result_t expected_modes[$];
    field_row_t   directed_rows[$];
    int           errors   = 0;
    bit           tx_idle  = 1'b1;
    bit           rx_idle  = 1'b1;
    bit           hold_req = 1'b0;

    motion_adaptive_mode_selector u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .field_difference (field_difference),
        .fields_present   (fields_present),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .selected_mode    (selected_mode),
        .processed        (processed),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Next mode for one field; updates the mode state
    function automatic mode_result_t select_mode(input logic [mams_pkg::DIFF_W-1:0] diff,
                                                 input logic present);
        mode_result_t res;
        if (!mode_set)
        begin
            pred_mode = cfg_high_mode;
            mode_set  = 1'b1;
        end
        if (present)
        begin
            if (diff > mams_pkg::DIFF_W'(cfg_motion_thr))
            begin
                quiet_run = '0;
                if (pred_mode == cfg_static_mode &&
                    diff < mams_pkg::DIFF_W'(cfg_mismatch_thr))
                    pred_mode = cfg_low_mode;
                else if (pred_mode != cfg_high_mode)
                    pred_mode = cfg_high_mode;
            end
            else
            begin
                if (quiet_run != mams_pkg::QUIET_MAX)
                    quiet_run = quiet_run + 1'b1;
                // high-to-low first, then low-to-static on the updated mode
                if (quiet_run >= cfg_low_count && pred_mode == cfg_high_mode)
                    pred_mode = cfg_low_mode;
                if (quiet_run >= cfg_static_count && pred_mode == cfg_low_mode)
                    pred_mode = cfg_static_mode;
            end
        end
        res.mode      = pred_mode;
        res.processed = present;
        return res;
    endfunction

    function automatic field_row_t dir_row(input logic [mams_pkg::DIFF_W-1:0] diff,
                                           input logic present, input bit typed,
                                           input logic [mams_pkg::MODE_W-1:0] mode);
        field_row_t row;
        row.diff             = diff;
        row.present          = present;
        row.typed            = typed;
        row.result.mode      = mode;
        row.result.processed = present;
        return row;
    endfunction

    // Random register values: boundaries, small values, full-width garbage
    function automatic logic [mams_pkg::CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return mams_pkg::CFG_DATA_W'(1);
            2:       return mams_pkg::CFG_DATA_W'(1000);
            6:       return mams_pkg::CFG_DATA_W'($urandom);
            default: return mams_pkg::CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [mams_pkg::CFG_DATA_W-1:0] pick_mode();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return mams_pkg::CFG_DATA_W'(99);
            2:       return mams_pkg::CFG_DATA_W'(127);
            6:       return mams_pkg::CFG_DATA_W'($urandom);
            default: return mams_pkg::CFG_DATA_W'($urandom_range(0, 3));   // likely to coincide
        endcase
    endfunction

    function automatic logic [mams_pkg::CFG_DATA_W-1:0] pick_limit(input int typical_hi,
                                                                   input int range_hi);
        case ($urandom_range(0, 6))
            0:       return mams_pkg::CFG_DATA_W'(1);
            1:       return mams_pkg::CFG_DATA_W'(range_hi);
            2:       return '1;
            6:       return mams_pkg::CFG_DATA_W'($urandom);
            default: return mams_pkg::CFG_DATA_W'($urandom_range(1, typical_hi));
        endcase
    endfunction

    function automatic logic [mams_pkg::DIFF_W-1:0] pick_diff(input bit quiet);
        int unsigned thr;
        int unsigned mis;
        thr = cfg_motion_thr;
        mis = cfg_mismatch_thr;
        if (quiet)
            return mams_pkg::DIFF_W'($urandom_range(0, thr));
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return mams_pkg::DIFF_W'(thr + $urandom_range(0, 2) - 1);
            3:       return mams_pkg::DIFF_W'(mis + $urandom_range(0, 2) - 1);
            4:       return mams_pkg::DIFF_W'($urandom);
            5:       return mams_pkg::DIFF_W'($urandom_range(thr, mis));
            default: return mams_pkg::DIFF_W'($urandom_range(thr + 1, thr + 64));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_val, act_val);
    endtask

    task automatic write_reg(input logic [mams_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mams_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            mams_pkg::REG_LOW_MOTION_COUNT:
                cfg_low_count    = data[mams_pkg::COUNT_W-1:0];
            mams_pkg::REG_STATIC_COUNT:
                cfg_static_count = data[mams_pkg::COUNT_W-1:0];
            mams_pkg::REG_STATIC_MODE:
                cfg_static_mode  = data[mams_pkg::MODE_W-1:0];
            mams_pkg::REG_LOW_MODE:
                cfg_low_mode     = data[mams_pkg::MODE_W-1:0];
            mams_pkg::REG_HIGH_MODE:
                cfg_high_mode    = data[mams_pkg::MODE_W-1:0];
            mams_pkg::REG_MOTION_THRESHOLD:
                cfg_motion_thr   = data[mams_pkg::MOTION_W-1:0];
            mams_pkg::REG_MISMATCH_THRESHOLD:
                cfg_mismatch_thr = data[mams_pkg::MISMATCH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic config_all(input logic [mams_pkg::CFG_DATA_W-1:0] low_cnt,
                              input logic [mams_pkg::CFG_DATA_W-1:0] st_cnt,
                              input logic [mams_pkg::CFG_DATA_W-1:0] st_mode,
                              input logic [mams_pkg::CFG_DATA_W-1:0] lo_mode,
                              input logic [mams_pkg::CFG_DATA_W-1:0] hi_mode,
                              input logic [mams_pkg::CFG_DATA_W-1:0] mot_thr,
                              input logic [mams_pkg::CFG_DATA_W-1:0] mis_thr);
        write_reg(mams_pkg::REG_LOW_MOTION_COUNT, low_cnt);
        write_reg(mams_pkg::REG_STATIC_COUNT, st_cnt);
        write_reg(mams_pkg::REG_STATIC_MODE, st_mode);
        write_reg(mams_pkg::REG_LOW_MODE, lo_mode);
        write_reg(mams_pkg::REG_HIGH_MODE, hi_mode);
        write_reg(mams_pkg::REG_MOTION_THRESHOLD, mot_thr);
        write_reg(mams_pkg::REG_MISMATCH_THRESHOLD, mis_thr);
        cfg_we <= 1'b0;
    endtask

    // Offer one field request and record its expected result once accepted
    task automatic send_field(input logic [mams_pkg::DIFF_W-1:0] diff, input logic present,
                              input bit typed, input mode_result_t typed_res);
        int gap;
        mode_result_t res;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        field_difference <= diff;
        fields_present   <= present;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = select_mode(diff, present);
        expected_modes.push_back(typed ? typed_res : res);
    endtask

    // Wait until every result is back and the pipeline is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_modes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin : field_source
        mode_result_t no_res;
        int           sent;
        int           run_len;
        bit           quiet;
        no_res = '{mode: '0, processed: 1'b0};

        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        field_difference <= '0;
        fields_present   <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first two fields on reset values, then a small-count setting
        directed_rows.push_back(dir_row('0, 1'b0, 1'b1, mams_pkg::RST_HIGH_MODE));
        directed_rows.push_back(dir_row('1, 1'b1, 1'b1, mams_pkg::RST_HIGH_MODE));
        directed_rows.push_back(dir_row(24'd16, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row(24'd15, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('1, 1'b0, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row(24'd899, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row(24'd900, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row(24'd1, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('1, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('1, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row(24'd16, 1'b1, 1'b0, '0));
        directed_rows.push_back(dir_row('0, 1'b0, 1'b0, '0));

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (i == CFG_ROW)
            begin
                drain_results();
                write_reg(REG_UNUSED, '1);
                config_all(2, 3, 0, 50, 99, 15, 900);
            end
            send_field(directed_rows[i].diff, directed_rows[i].present,
                       directed_rows[i].typed, directed_rows[i].result);
        end
        drain_results();

        // random phases: quiet runs with motion bursts and noise in between
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       config_all(1, 1, 0, 1, 2, 15, 900);      // both steps on one field
                1:       config_all(0, 0, 5, 6, 7, 1, 1);         // zero counts
                2:       config_all(2, 3, 9, 9, 9, 20, 100);      // coinciding modes
                default: config_all(pick_count(), pick_count(), pick_mode(), pick_mode(),
                                    pick_mode(), pick_limit(64, 5000), pick_limit(2000, 10000));
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (phase == HOLD_PHASE)
            begin
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(1, 10);
                quiet   = ($urandom_range(0, 9) < 6);
                for (int k = 0; k < run_len; k++)
                begin
                    send_field(pick_diff(quiet), ($urandom_range(0, 9) != 0), 1'b0, no_res);
                    sent++;
                end
            end
            drain_results();
        end

        // long quiet stretch at full-width thresholds, passing both large counts
        config_all(40, 55, 0, 1, 2, 8191, 16383);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int k = 0; k < QUIET_ITEMS; k++)
            send_field(mams_pkg::DIFF_W'($urandom_range(0, 8191)), 1'b1, 1'b0, no_res);
        send_field('1, 1'b1, 1'b0, no_res);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off, compare against the oldest expectation
    initial
    begin : result_sink
        int           stall;
        mode_result_t want;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            else
                stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_modes.size() == 0)
                note_mismatch("result with none pending, mode", -1, selected_mode);
            else
            begin
                want = expected_modes.pop_front();
                if (selected_mode !== want.mode)
                    note_mismatch("selected_mode", want.mode, selected_mode);
                if (processed !== want.processed)
                    note_mismatch("processed", want.processed, processed);
            end
        end
    end

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
